// ===== rtl/pstf_pkg.sv =====
// pstf_pkg: types, register codes and constants of the ping-pong sine tone frame unit
// no dependencies
package pstf_pkg;

	localparam int MAX_PERIOD_DEF = 1024;
	localparam int CHANNELS_DEF   = 8;
	localparam int BUFFER_MS_DEF  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int RATE_W     = 16;
	localparam int TONE_W     = 15;
	localparam int AMP_W      = 31;
	localparam int SAMPLE_W   = 32;
	localparam int SLOT_W     = 3;
	localparam int WCOUNT_W   = 12;

	localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP  = 2'd2;

	localparam logic [RATE_W-1:0] RATE_RST = 16'd48000;
	localparam logic [TONE_W-1:0] TONE_RST = 15'd1000;
	localparam logic [AMP_W-1:0]  AMP_RST  = 31'd1073741824;

	localparam int BUF_RATE_CAP = 48000;
	localparam int MS_DIV       = 1000;

	// floor(x/1000) = (x*MS_RECIP) >> MS_RECIP_SHIFT for x up to 48000
	localparam logic [31:0] MS_RECIP       = 32'd67109;
	localparam int          MS_RECIP_SHIFT = 26;

	localparam logic [30:0] Q30_ONE     = 31'd1073741824;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	localparam int HORNER_TERMS = 6;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0_0000_0000_0001,
		ST_BUFD  = 13'b0_0000_0000_0010,
		ST_PERD  = 13'b0_0000_0000_0100,
		ST_MODD  = 13'b0_0000_0000_1000,
		ST_PHD   = 13'b0_0000_0001_0000,
		ST_MULR  = 13'b0_0000_0010_0000,
		ST_MULR2 = 13'b0_0000_0100_0000,
		ST_HMUL  = 13'b0_0000_1000_0000,
		ST_HREC  = 13'b0_0001_0000_0000,
		ST_HCOR  = 13'b0_0010_0000_0000,
		ST_SMUL  = 13'b0_0100_0000_0000,
		ST_AMUL  = 13'b0_1000_0000_0000,
		ST_OUT   = 13'b1_0000_0000_0000
	} state_t;

	function automatic logic [RATE_W-1:0] horner_div(input logic [2:0] k);
		logic [RATE_W-1:0] d;
		unique case (k)
			3'd0: d = 16'd156;
			3'd1: d = 16'd110;
			3'd2: d = 16'd72;
			3'd3: d = 16'd42;
			3'd4: d = 16'd20;
			3'd5: d = 16'd6;
			default: d = 16'd6;
		endcase
		return d;
	endfunction

	// floor(2^32 / horner_div(k))
	function automatic logic [31:0] horner_recip(input logic [2:0] k);
		logic [31:0] m;
		unique case (k)
			3'd0: m = 32'd27531841;
			3'd1: m = 32'd39045157;
			3'd2: m = 32'd59652323;
			3'd3: m = 32'd102261126;
			3'd4: m = 32'd214748364;
			3'd5: m = 32'd715827882;
			default: m = 32'd715827882;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/pingpong_sine_tone_frames_unit.sv =====
// ping-pong sine tone frame unit: one CHANNELS-word audio frame per frame tick
// a tick is taken only in the idle state; the frame is computed by three bit-serial divisions
// on the shared divider and by the shared 32x32 multiplier, then words leave one per cycle
// while out_ready is high
// reset: asynchronous, registers to defaults, sweep and buffer counters cleared
// depends on pstf_pkg
module pingpong_sine_tone_frames_unit #(
	parameter int MAX_PERIOD = pstf_pkg::MAX_PERIOD_DEF,
	parameter int CHANNELS   = pstf_pkg::CHANNELS_DEF,
	parameter int BUFFER_MS  = pstf_pkg::BUFFER_MS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pstf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pstf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                frame_tick,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pstf_pkg::SAMPLE_W-1:0] sample_word,
	output logic [pstf_pkg::SLOT_W-1:0]         channel_slot,
	output logic                                last_of_frame,
	output logic                                end_of_buffer,
	output logic                                buffer_select,
	output logic [pstf_pkg::WCOUNT_W-1:0]       buffer_word_count
);
	import pstf_pkg::*;

	localparam int WI_W = (MAX_PERIOD > 2) ? $clog2(MAX_PERIOD) : 1;
	localparam int PER_W = $clog2(MAX_PERIOD + 1);
	localparam int BUF_FRAMES_MAX = (BUF_RATE_CAP / MS_DIV) * BUFFER_MS;
	localparam int FR_W = $clog2(BUF_FRAMES_MAX + 1);
	localparam logic [5:0] DIV_LAST = 6'd32;

	state_t state_q;
	logic [5:0] cnt_q;
	logic [2:0] k_q;
	logic [SLOT_W-1:0] ch_q;
	logic out_valid_q;
	logic [WI_W-1:0] wave_q;
	logic up_q;
	logic [FR_W-1:0] fib_q;
	logic active_q;
	logic [RATE_W-1:0] rate_q;
	logic [TONE_W-1:0] tone_q;
	logic [AMP_W-1:0] amp_q;

	logic [31:0] div_d_q;
	logic [15:0] div_r_q;
	logic [15:0] div_v_q;
	logic [FR_W-1:0] frames_q;
	logic [PER_W-1:0] per_q;
	logic [1:0] quad_q;
	logic [30:0] x_q;
	logic [30:0] r_q;
	logic [31:0] r2_q;
	logic [30:0] t_q;
	logic [31:0] qe_q;
	logic [30:0] s_q;
	logic [31:0] sample_q;

	logic signed [SAMPLE_W-1:0] sample_word_q;
	logic [SLOT_W-1:0] channel_slot_q;
	logic last_q;
	logic eob_q;
	logic bsel_q;
	logic [WCOUNT_W-1:0] wcount_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [16:0] div_trial;
	logic [16:0] div_sub;
	logic div_ge;
	logic div_fin;
	logic in_xfer;
	logic cfg_hit;
	logic load_word;
	logic last_word;
	logic buffer_end;
	logic [RATE_W-1:0] rate_b;
	logic [FR_W-1:0] fr_calc;
	logic [31:0] per_raw;
	logic [PER_W-1:0] per_calc;
	logic [29:0] ph_f;
	logic [30:0] x_calc;
	logic [31:0] hc_rem;
	logic hc_ge;
	logic [30:0] t_dec;
	logic [30:0] t_next;
	logic [30:0] s_calc;
	logic [30:0] mag;
	logic [31:0] sample_calc;
	logic [15:0] words;
	logic [PER_W-1:0] wave_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign cfg_hit = cfg_we && (cfg_index == REG_RATE || cfg_index == REG_TONE ||
		cfg_index == REG_AMP);
	assign div_fin = (cnt_q == DIV_LAST);
	assign load_word = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign last_word = (ch_q == SLOT_W'(CHANNELS - 1));
	assign buffer_end = ({1'b0, fib_q} + 1'b1) >= {1'b0, frames_q};
	assign words = 16'(frames_q) * 16'(CHANNELS);
	assign wave_inc = PER_W'(wave_q) + 1'b1;

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_BUFD: begin
				mul_a = 32'(rate_b);
				mul_b = MS_RECIP;
			end
			ST_PERD: begin
				mul_a = 32'(wave_q);
				mul_b = 32'(tone_q);
			end
			ST_MULR: begin
				mul_a = {1'b0, x_q};
				mul_b = HALF_PI_Q30;
			end
			ST_MULR2: begin
				mul_a = {1'b0, r_q};
				mul_b = {1'b0, r_q};
			end
			ST_HMUL: begin
				mul_a = r2_q;
				mul_b = {1'b0, t_q};
			end
			ST_HREC: begin
				mul_a = div_d_q;
				mul_b = horner_recip(k_q);
			end
			ST_HCOR: begin
				mul_a = qe_q;
				mul_b = 32'(div_v_q);
			end
			ST_SMUL: begin
				mul_a = {1'b0, r_q};
				mul_b = {1'b0, t_q};
			end
			ST_AMUL: begin
				mul_a = {1'b0, amp_q};
				mul_b = {1'b0, s_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// shared restoring divider step
	assign div_trial = {div_r_q, div_d_q[31]};
	assign div_ge = div_trial >= {1'b0, div_v_q};
	assign div_sub = div_trial - {1'b0, div_v_q};

	always_comb begin
		rate_b = (rate_q > RATE_W'(BUF_RATE_CAP)) ? RATE_W'(BUF_RATE_CAP) : rate_q;
		fr_calc = FR_W'(mul_p[MS_RECIP_SHIFT +: 6]) * FR_W'(BUFFER_MS);
		if (fr_calc == '0) begin
			fr_calc = FR_W'(1);
		end
		per_raw = div_d_q;
		if (tone_q == '0) begin
			per_calc = PER_W'(MAX_PERIOD);
		end else if (per_raw < 32'd2) begin
			per_calc = PER_W'(2);
		end else if (per_raw > 32'(MAX_PERIOD)) begin
			per_calc = PER_W'(MAX_PERIOD);
		end else begin
			per_calc = per_raw[PER_W-1:0];
		end
		ph_f = div_d_q[29:0];
		x_calc = div_d_q[30] ? (Q30_ONE - {1'b0, ph_f}) : {1'b0, ph_f};
		// reciprocal estimate is low by at most one
		hc_rem = div_d_q - mul_p[31:0];
		hc_ge = hc_rem >= 32'(div_v_q);
		t_dec = Q30_ONE - qe_q[30:0];
		t_next = hc_ge ? (t_dec - 31'd1) : t_dec;
		s_calc = (mul_p[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : mul_p[60:30];
		mag = mul_p[60:30];
		if (rate_q == '0 || tone_q == '0) begin
			sample_calc = '0;
		end else if (quad_q[1]) begin
			sample_calc = 32'd0 - {1'b0, mag};
		end else begin
			sample_calc = {1'b0, mag};
		end
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			ch_q <= '0;
			out_valid_q <= 1'b0;
			wave_q <= '0;
			up_q <= 1'b1;
			fib_q <= '0;
			active_q <= 1'b0;
			rate_q <= RATE_RST;
			tone_q <= TONE_RST;
			amp_q <= AMP_RST;
		end else begin
			if (load_word) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				unique case (cfg_index)
					REG_RATE: rate_q <= cfg_wdata[RATE_W-1:0];
					REG_TONE: tone_q <= cfg_wdata[TONE_W-1:0];
					REG_AMP:  amp_q <= cfg_wdata[AMP_W-1:0];
					default:  amp_q <= amp_q;
				endcase
				wave_q <= '0;
				up_q <= 1'b1;
				fib_q <= '0;
				active_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer && frame_tick) begin
						state_q <= ST_BUFD;
					end
				end
				ST_BUFD: begin
					cnt_q <= '0;
					state_q <= ST_PERD;
				end
				ST_PERD, ST_MODD, ST_PHD: begin
					if (!div_fin) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q <= '0;
						unique case (state_q)
							ST_PERD: state_q <= ST_MODD;
							ST_MODD: state_q <= ST_PHD;
							default: state_q <= ST_MULR;
						endcase
					end
				end
				ST_MULR: state_q <= ST_MULR2;
				ST_MULR2: begin
					k_q <= '0;
					state_q <= ST_HMUL;
				end
				ST_HMUL: state_q <= ST_HREC;
				ST_HREC: state_q <= ST_HCOR;
				ST_HCOR: begin
					if (k_q == 3'(HORNER_TERMS - 1)) begin
						state_q <= ST_SMUL;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_HMUL;
					end
				end
				ST_SMUL: state_q <= ST_AMUL;
				ST_AMUL: begin
					ch_q <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_word) begin
						if (last_word) begin
							state_q <= ST_IDLE;
							ch_q <= '0;
							if (up_q) begin
								if (wave_inc >= per_q) begin
									wave_q <= WI_W'(per_q - PER_W'(2));
									up_q <= 1'b0;
								end else begin
									wave_q <= wave_inc[WI_W-1:0];
								end
							end else if (wave_q == '0) begin
								up_q <= 1'b1;
								wave_q <= WI_W'(1);
							end else begin
								wave_q <= wave_q - 1'b1;
							end
							if (buffer_end) begin
								fib_q <= '0;
								active_q <= ~active_q;
							end else begin
								fib_q <= fib_q + 1'b1;
							end
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_BUFD: begin
				frames_q <= fr_calc;
				div_d_q <= 32'(rate_q);
				div_v_q <= 16'(tone_q);
				div_r_q <= '0;
			end
			ST_PERD, ST_MODD, ST_PHD: begin
				if (!div_fin) begin
					div_r_q <= div_ge ? div_sub[15:0] : div_trial[15:0];
					div_d_q <= {div_d_q[30:0], div_ge};
				end else begin
					unique case (state_q)
						ST_PERD: begin
							per_q <= per_calc;
							div_d_q <= mul_p[31:0];
							div_v_q <= rate_q;
							div_r_q <= '0;
						end
						ST_MODD: div_d_q <= '0;
						default: begin
							quad_q <= div_d_q[31:30];
							x_q <= x_calc;
						end
					endcase
				end
			end
			ST_MULR: r_q <= mul_p[60:30];
			ST_MULR2: begin
				r2_q <= mul_p[61:30];
				t_q <= Q30_ONE;
			end
			ST_HMUL: begin
				div_d_q <= mul_p[61:30];
				div_v_q <= horner_div(k_q);
			end
			ST_HREC: qe_q <= mul_p[63:32];
			ST_HCOR: t_q <= t_next;
			ST_SMUL: s_q <= s_calc;
			ST_AMUL: sample_q <= sample_calc;
			default: sample_q <= sample_q;
		endcase
		if (load_word) begin
			sample_word_q <= (ch_q < SLOT_W'(2)) ? sample_q : '0;
			channel_slot_q <= ch_q;
			last_q <= last_word;
			eob_q <= last_word && buffer_end;
			bsel_q <= active_q;
			wcount_q <= words[WCOUNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign sample_word = sample_word_q;
	assign channel_slot = channel_slot_q;
	assign last_of_frame = last_q;
	assign end_of_buffer = eob_q;
	assign buffer_select = bsel_q;
	assign buffer_word_count = wcount_q;

`ifndef NO_ASSERTIONS
	a_last_word_frees: assert property (@(posedge clk) disable iff (!arst_n)
		load_word && last_word |=> in_ready)
		else $error("unit not ready after last word of frame");

	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MODD |-> (per_q >= PER_W'(2) && per_q <= PER_W'(MAX_PERIOD)))
		else $error("period out of range");

	a_out_only_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("output word raised outside frame emission");
`endif

endmodule
